@@ src/bqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqe_pkg: shared constants for the billboard quad expander
// Holds the default trig table settings, fixed-point widths, the
// configuration register indexes and the series divisors for the sine table.
// ----------------------------------------------------------------------------
package bqe_pkg;

    // Default trig table shape.
    localparam int SINE_DEPTH_DEF = 256;
    localparam int TRIG_FRAC_DEF  = 14;

    // Quarter turn in Q30 and the basis fraction bits.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int BASIS_FRAC = 14;

    // Rounded axis offsets always fit this many signed bits.
    localparam int AX_W = 21;

    // Vertex limits, signed Q17.8.
    localparam int VERT_W = 25;
    localparam logic signed [25:0] VERT_MAX = 26'sd16777215;
    localparam logic signed [25:0] VERT_MIN = -26'sd16777216;

    // Stream widths.
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 144;
    localparam int SIDE_W     = 168;

    // Divisors (2k)(2k+1) of the sine series, k = 1..12.
    localparam longint unsigned TAYLOR_DIV [1:12] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_RIGHT_X = 3'd0,
        REG_RIGHT_Y = 3'd1,
        REG_RIGHT_Z = 3'd2,
        REG_UP_X    = 3'd3,
        REG_UP_Y    = 3'd4,
        REG_UP_Z    = 3'd5
    } t_cfg_reg;

    // Corner codes.
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

endpackage

@@ src/billboard_quad_expander.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_quad_expander: sprite to four quad corners
// A request passes stages 1 to 4 and then the output register, which presents the first vertex.
// The single vertex output holds each sprite for its four corners;
// the input side takes a new request every cycle while pipeline stages are free.
// Inactive or colorless sprites are dropped at the first stage.
// Reset is synchronous, active low; it clears valids and restores the basis.
// ----------------------------------------------------------------------------
module billboard_quad_expander #(
    parameter int SINE_TABLE_DEPTH = bqe_pkg::SINE_DEPTH_DEF,
    parameter int TRIG_FRAC_BITS   = bqe_pkg::TRIG_FRAC_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_addr,
    input  logic [15:0]                    i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, pos_z, half_size, angle, tex_u_left, tex_v_top,
    // tex_u_right, tex_v_bottom, rgba
    input  logic [bqe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // ground_flat, active
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // vert_x, vert_y, vert_z, vert_u, vert_v, vert_rgba, zero fill
    output logic [bqe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // corner
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int F     = TRIG_FRAC_BITS;
    localparam int SN_W  = F + 2;
    localparam int P_W   = 33;
    localparam int SUM_W = P_W + SN_W + 1;
    localparam int SH    = bqe_pkg::BASIS_FRAC + F;
    localparam int LW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MUL_W = 14 + LW;
    localparam int AX_W  = bqe_pkg::AX_W;
    localparam int SW    = bqe_pkg::SIDE_W;

    typedef logic [F:0] t_lut [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine table, built by series expansion at elaboration.
    function automatic t_lut build_lut();
        t_lut             lut;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           sum;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
            if (j == SINE_TABLE_DEPTH) begin
                lut[j] = (F+1)'(longint'(1) << F);
            end else begin
                x    = (bqe_pkg::HALF_PI_Q30 * longint'(j)) / SINE_TABLE_DEPTH;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int k = 1; k <= 12; k++) begin
                    term = ((term * x2) >> 30) / bqe_pkg::TAYLOR_DIV[k];
                    if (k % 2 == 1) sum = sum - longint'(term);
                    else            sum = sum + longint'(term);
                end
                if (sum < 0) sum = 0;
                if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
                lut[j] = (F+1)'((sum + (longint'(1) << (29 - F))) >> (30 - F));
            end
        end
        return lut;
    endfunction

    localparam t_lut SINE_LUT = build_lut();

    // Sine of a 16-bit turn angle from the quarter-wave table.
    function automatic logic signed [SN_W-1:0] trig(input logic [15:0] a);
        logic [MUL_W-1:0] prod;
        logic [LW-1:0]    idx;
        logic [LW-1:0]    sel;
        logic [SN_W-1:0]  mag;
        prod = MUL_W'(a[13:0]) * MUL_W'(SINE_TABLE_DEPTH);
        idx  = LW'(prod >> 14);
        sel  = a[14] ? (LW'(SINE_TABLE_DEPTH) - idx) : idx;
        mag  = {1'b0, SINE_LUT[sel]};
        return a[15] ? $signed(-mag) : $signed(mag);
    endfunction

    // Round half up, then drop the fraction.
    function automatic logic signed [AX_W-1:0] rnd(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + (SUM_W'(1) <<< (SH - 1));
        return AX_W'(t >>> SH);
    endfunction

    // Clamp to the vertex range.
    function automatic logic [bqe_pkg::VERT_W-1:0] sat(input logic signed [25:0] v);
        logic signed [25:0] c;
        c = v;
        if (v > bqe_pkg::VERT_MAX) c = bqe_pkg::VERT_MAX;
        if (v < bqe_pkg::VERT_MIN) c = bqe_pkg::VERT_MIN;
        return c[bqe_pkg::VERT_W-1:0];
    endfunction

    // Camera basis registers.
    logic signed [15:0] r_right [3];
    logic signed [15:0] r_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right[0] <= 16'sd16384;
            r_right[1] <= 16'sd0;
            r_right[2] <= 16'sd0;
            r_up[0]    <= 16'sd0;
            r_up[1]    <= 16'sd16384;
            r_up[2]    <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bqe_pkg::REG_RIGHT_X: r_right[0] <= i_cfg_wdata;
                bqe_pkg::REG_RIGHT_Y: r_right[1] <= i_cfg_wdata;
                bqe_pkg::REG_RIGHT_Z: r_right[2] <= i_cfg_wdata;
                bqe_pkg::REG_UP_X:    r_up[0]    <= i_cfg_wdata;
                bqe_pkg::REG_UP_Y:    r_up[1]    <= i_cfg_wdata;
                bqe_pkg::REG_UP_Z:    r_up[2]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline registers.
    logic                    r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_o_valid;
    logic [SW-1:0]           r_s1_side, r_s2_side, r_s3_side, r_s4_side, r_o_side;
    logic [15:0]             r_s1_size, r_s2_size;
    logic [15:0]             r_s1_angle;
    logic                    r_s1_flat;
    logic signed [SN_W-1:0]  r_s2_sn, r_s2_cs, r_s3_sn, r_s3_cs;
    logic signed [15:0]      r_s2_rv [3];
    logic signed [15:0]      r_s2_uv [3];
    logic signed [P_W-1:0]   r_s3_p [3];
    logic signed [P_W-1:0]   r_s3_q [3];
    logic signed [SUM_W-1:0] r_s4_a [3];
    logic signed [SUM_W-1:0] r_s4_b [3];
    logic signed [AX_W-1:0]  r_o_r [3];
    logic signed [AX_W-1:0]  r_o_u [3];
    logic [1:0]              r_o_corner;

    // Stage readiness ripples back from the vertex output.
    logic w_o_rdy, w_s4_rdy, w_s3_rdy, w_s2_rdy, w_s1_rdy;
    assign w_o_rdy  = !r_o_valid || (m_axis_tready && r_o_corner == bqe_pkg::CORNER_LAST);
    assign w_s4_rdy = !r_s4_valid || w_o_rdy;
    assign w_s3_rdy = !r_s3_valid || w_s4_rdy;
    assign w_s2_rdy = !r_s2_valid || w_s3_rdy;
    assign w_s1_rdy = !r_s1_valid || w_s2_rdy;
    assign s_axis_tready = w_s1_rdy;

    // Stage 1: capture the request; drop inactive or colorless sprites.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_valid <= s_axis_tvalid && s_axis_tuser[1] && (s_axis_tdata[199:168] != 32'd0);
        end
        if (w_s1_rdy) begin
            r_s1_side  <= {s_axis_tdata[199:104], s_axis_tdata[71:0]};
            r_s1_size  <= s_axis_tdata[87:72];
            r_s1_angle <= s_axis_tdata[103:88];
            r_s1_flat  <= s_axis_tuser[0];
        end
    end

    // Stage 2 logic: trig lookup and basis choice. Angle zero acts as
    // sine one, cosine zero; ground-flat mode uses fixed X/Z unit axes.
    logic signed [SN_W-1:0] n_sn, n_cs;
    logic signed [15:0]     n_rv [3];
    logic signed [15:0]     n_uv [3];
    always_comb begin
        if (r_s1_angle == 16'd0) begin
            n_sn = SN_W'(1) <<< F;
            n_cs = '0;
        end else begin
            n_sn = trig(r_s1_angle);
            n_cs = trig(r_s1_angle + 16'd16384);
        end
        if (r_s1_flat) begin
            n_rv[0] = -16'sd16384;
            n_rv[1] = 16'sd0;
            n_rv[2] = 16'sd0;
            n_uv[0] = 16'sd0;
            n_uv[1] = 16'sd0;
            n_uv[2] = 16'sd16384;
        end else begin
            n_rv = r_right;
            n_uv = r_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_s2_rdy) begin
            r_s2_side <= r_s1_side;
            r_s2_size <= r_s1_size;
            r_s2_sn   <= n_sn;
            r_s2_cs   <= n_cs;
            r_s2_rv   <= n_rv;
            r_s2_uv   <= n_uv;
        end
    end

    // Stage 3: scale both basis vectors by the half size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_rdy) begin
            r_s3_valid <= r_s2_valid;
        end
        if (w_s3_rdy) begin
            r_s3_side <= r_s2_side;
            r_s3_sn   <= r_s2_sn;
            r_s3_cs   <= r_s2_cs;
            for (int i = 0; i < 3; i++) begin
                r_s3_p[i] <= $signed({1'b0, r_s2_size}) * r_s2_rv[i];
                r_s3_q[i] <= $signed({1'b0, r_s2_size}) * r_s2_uv[i];
            end
        end
    end

    // Stage 4: rotate the scaled axes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_s4_rdy) begin
            r_s4_valid <= r_s3_valid;
        end
        if (w_s4_rdy) begin
            r_s4_side <= r_s3_side;
            for (int i = 0; i < 3; i++) begin
                r_s4_a[i] <= SUM_W'(r_s3_p[i] * r_s3_sn) - SUM_W'(r_s3_q[i] * r_s3_cs);
                r_s4_b[i] <= SUM_W'(r_s3_q[i] * r_s3_sn) + SUM_W'(r_s3_p[i] * r_s3_cs);
            end
        end
    end

    // Output stage: round the axes and step through the four corners.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_o_corner <= bqe_pkg::CORNER_FIRST;
        end else if (w_o_rdy) begin
            r_o_valid  <= r_s4_valid;
            r_o_corner <= bqe_pkg::CORNER_FIRST;
        end else if (m_axis_tready) begin
            r_o_corner <= r_o_corner + 2'd1;
        end
        if (w_o_rdy) begin
            r_o_side <= r_s4_side;
            for (int i = 0; i < 3; i++) begin
                r_o_r[i] <= rnd(r_s4_a[i]);
                r_o_u[i] <= rnd(r_s4_b[i]);
            end
        end
    end

    // Corner vertex: center plus or minus each axis, then clamp.
    logic                      w_pos_r, w_pos_u;
    logic signed [25:0]        w_sum [3];
    logic [bqe_pkg::VERT_W-1:0] w_vert [3];
    always_comb begin
        w_pos_r = (r_o_corner == 2'd1) || (r_o_corner == 2'd2);
        w_pos_u = (r_o_corner == 2'd0) || (r_o_corner == 2'd1);
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = 26'($signed(r_o_side[i*24 +: 24]))
                     + (w_pos_r ? 26'(r_o_r[i]) : -26'(r_o_r[i]))
                     + (w_pos_u ? 26'(r_o_u[i]) : -26'(r_o_u[i]));
            w_vert[i] = sat(w_sum[i]);
        end
    end

    // Side layout: pos [71:0], u_left [87:72], v_top [103:88],
    // u_right [119:104], v_bottom [135:120], rgba [167:136].
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_corner;
    assign m_axis_tlast  = (r_o_corner == bqe_pkg::CORNER_LAST);
    assign m_axis_tdata  = {5'd0,
                            r_o_side[167:136],
                            w_pos_u ? r_o_side[103:88] : r_o_side[135:120],
                            w_pos_r ? r_o_side[119:104] : r_o_side[87:72],
                            w_vert[2], w_vert[1], w_vert[0]};

endmodule

@@ src/bqe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqe_checker: port-level checks for the billboard quad expander
// Watches the vertex stream for corner order, last marking, color, reset and stalled-vertex hold.
// ----------------------------------------------------------------------------
module bqe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bqe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    // Last is marked exactly on the fourth corner.
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == bqe_pkg::CORNER_LAST)))
        else $error("tlast does not match the final corner");

    // Corners of one quad follow back to back in order.
    a_corner_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("corner sequence broken");

    // Colorless sprites never reach the output.
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[138:107] != 32'd0))
        else $error("vertex with zero color");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled vertex holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled vertex changed");

endmodule

bind billboard_quad_expander bqe_checker u_bqe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
